// File: sv/kpct_pkg.sv
package kpct_pkg;

  // Table geometry
  localparam int BUCKET_BITS = 10;
  localparam int WAYS        = 4;
  localparam int NUM_SLOTS   = (1 << BUCKET_BITS) * WAYS;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int WCNT_W      = $clog2(WAYS + 1);

  // Field widths
  localparam int ID_W      = 22;
  localparam int CNT_W     = 32;
  localparam int IDX_W     = 12;
  localparam int IDX_EXT_W = (SLOT_W + 1 > IDX_W) ? SLOT_W + 1 : IDX_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_SENT = 2'd0,
    ACT_RECV = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // One table entry
  typedef struct packed {
    logic             used;
    logic [ID_W-1:0]  owner;
    logic [CNT_W-1:0] sent;
    logic [CNT_W-1:0] recv;
  } entry_t;

  // Table port request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  // One result beat
  typedef struct packed {
    logic             hit;
    logic             dropped;
    logic             slot_valid;
    logic [ID_W-1:0]  owner_id;
    logic [CNT_W-1:0] sent_total;
    logic [CNT_W-1:0] recv_total;
  } res_t;

endpackage

// File: sv/keyed_packet_counter_table.sv
// Channel | Dir | Handshake              | Beat fields
// in      | in  | in_valid_i / in_stall_o | action_i, proc_id_i, slot_index_i
// out     | out | out_valid_o / out_stall_i | hit_o, dropped_o, slot_valid_o,
//         |     |                        | owner_id_o, sent_total_o, recv_total_o
//
// A count beat walks the bucket one way per cycle through the single table read
// port and one shared compare/increment unit. A read-and-clear beat passes through
// a read request state and a check-and-clear state; an unknown action or an
// out-of-range slot goes straight to the result. After reset a clearing pass
// writes every slot with in_stall_o high. A result waits in the output register
// under out_stall_i; the next input beat is taken once that result is registered.
module keyed_packet_counter_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [kpct_pkg::ID_W-1:0]   proc_id_i,
  input  logic [kpct_pkg::IDX_W-1:0]  slot_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic                        dropped_o,
  output logic                        slot_valid_o,
  output logic [kpct_pkg::ID_W-1:0]   owner_id_o,
  output logic [kpct_pkg::CNT_W-1:0]  sent_total_o,
  output logic [kpct_pkg::CNT_W-1:0]  recv_total_o
);
  import kpct_pkg::*;

  mem_req_t req;
  entry_t   rdata;
  logic     in_ready;
  logic     res_valid;
  logic     res_take;
  res_t     res;
  logic     out_valid_q;
  res_t     out_q;

  kpct_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .action_i     (action_i),
    .proc_id_i    (proc_id_i),
    .slot_index_i (slot_index_i),
    .req_o        (req),
    .rdata_i      (rdata),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res)
  );

  kpct_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // Output register takes a result when empty or being drained
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign in_stall_o   = !in_ready;
  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_q.hit;
  assign dropped_o    = out_q.dropped;
  assign slot_valid_o = out_q.slot_valid;
  assign owner_id_o   = out_q.owner_id;
  assign sent_total_o = out_q.sent_total;
  assign recv_total_o = out_q.recv_total;

endmodule

// File: sv/kpct_store.sv
module kpct_store (
  input  logic              clk_i,
  input  kpct_pkg::mem_req_t req_i,
  output kpct_pkg::entry_t   rdata_o
);
  import kpct_pkg::*;

  entry_t mem [NUM_SLOTS];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/kpct_unit.sv
module kpct_unit (
  input  kpct_pkg::entry_t              entry_i,
  input  logic [kpct_pkg::ID_W-1:0]     id_i,
  input  logic [kpct_pkg::CNT_W-1:0]    cnt_i,
  output logic                          match_o,
  output logic [kpct_pkg::CNT_W-1:0]    inc_o
);
  import kpct_pkg::*;

  // Key compare, used while walking the ways
  assign match_o = entry_i.used && (entry_i.owner == id_i);

  // Saturating increment, used on the update
  assign inc_o = (cnt_i == CNT_MAX) ? cnt_i : cnt_i + CNT_W'(1);

endmodule

// File: sv/kpct_ctrl.sv
module kpct_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [kpct_pkg::ID_W-1:0]  proc_id_i,
  input  logic [kpct_pkg::IDX_W-1:0] slot_index_i,
  output kpct_pkg::mem_req_t         req_o,
  input  kpct_pkg::entry_t           rdata_i,
  output logic                       res_valid_o,
  input  logic                       res_take_i,
  output kpct_pkg::res_t             res_o
);
  import kpct_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_RDREQ  = 7'b0010000,
    S_RDCHK  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   clr_q, clr_d;
  logic [WCNT_W-1:0]   way_q, way_d;
  logic                chk_q, chk_d;
  logic                chk_last_q, chk_last_d;
  logic                found_q, found_d;
  logic                free_q, free_d;

  action_e             act_q, act_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]   chk_addr_q, chk_addr_d;
  logic [SLOT_W-1:0]   tgt_addr_q, tgt_addr_d;
  logic [SLOT_W-1:0]   free_addr_q, free_addr_d;
  entry_t              cur_q, cur_d;
  res_t                res_q, res_d;

  logic [IDX_EXT_W-1:0] idx_ext;
  logic                 idx_ok;
  logic [SLOT_W-1:0]    way_addr;
  logic                 way_left;
  logic                 match;
  logic [CNT_W-1:0]     cnt_sel;
  logic [CNT_W-1:0]     cnt_inc;
  entry_t               new_ent;

  // Slot index range check on the incoming beat
  assign idx_ext = IDX_EXT_W'(slot_index_i);
  assign idx_ok  = idx_ext < IDX_EXT_W'(NUM_SLOTS);

  // Address of the way being issued
  assign way_addr = SLOT_W'(SLOT_W'(id_q[BUCKET_BITS-1:0]) * SLOT_W'(WAYS)
                    + SLOT_W'(way_q));
  assign way_left = way_q < WCNT_W'(WAYS);

  // Counter feeding the incrementer: zero for a freshly claimed slot
  always_comb begin
    if (!found_q) begin
      cnt_sel = '0;
    end else if (act_q == ACT_SENT) begin
      cnt_sel = cur_q.sent;
    end else begin
      cnt_sel = cur_q.recv;
    end
  end

  kpct_unit u_unit (
    .entry_i (rdata_i),
    .id_i    (id_q),
    .cnt_i   (cnt_sel),
    .match_o (match),
    .inc_o   (cnt_inc)
  );

  // Entry written back on a counted event
  always_comb begin
    new_ent = found_q ? cur_q : '0;
    new_ent.used  = 1'b1;
    new_ent.owner = id_q;
    if (act_q == ACT_SENT) begin
      new_ent.sent = cnt_inc;
    end else begin
      new_ent.recv = cnt_inc;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    way_d       = way_q;
    chk_d       = 1'b0;
    chk_last_d  = chk_last_q;
    found_d     = found_q;
    free_d      = free_q;
    act_d       = act_q;
    id_d        = id_q;
    idx_d       = idx_q;
    chk_addr_d  = chk_addr_q;
    tgt_addr_d  = tgt_addr_q;
    free_addr_d = free_addr_q;
    cur_d       = cur_q;
    res_d       = res_q;
    req_o       = '0;

    unique case (state_q)
      S_CLEAR: begin
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = clr_q;
        clr_d         = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(NUM_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_e'(action_i);
          id_d    = proc_id_i;
          idx_d   = idx_ext[SLOT_W-1:0];
          res_d   = '0;
          way_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          unique case (action_e'(action_i))
            ACT_SENT, ACT_RECV: state_d = S_SCAN;
            ACT_READ:           state_d = idx_ok ? S_RDREQ : S_DONE;
            default:            state_d = S_DONE;
          endcase
        end
      end

      // Issue one way per cycle, check the previous one
      S_SCAN: begin
        req_o.rd_en   = way_left;
        req_o.rd_addr = way_addr;
        if (way_left) begin
          chk_d      = 1'b1;
          chk_addr_d = way_addr;
          chk_last_d = (way_q == WCNT_W'(WAYS - 1));
          way_d      = way_q + WCNT_W'(1);
        end
        if (chk_q) begin
          if (match && !found_q) begin
            found_d    = 1'b1;
            tgt_addr_d = chk_addr_q;
            cur_d      = rdata_i;
          end else if (!rdata_i.used && !free_q) begin
            free_d      = 1'b1;
            free_addr_d = chk_addr_q;
          end
          if (chk_last_q) begin
            state_d = S_UPDATE;
          end
        end
      end

      S_UPDATE: begin
        req_o.wr_data = new_ent;
        if (found_q) begin
          res_d.hit     = 1'b1;
          req_o.wr_en   = 1'b1;
          req_o.wr_addr = tgt_addr_q;
        end else if (free_q) begin
          req_o.wr_en   = 1'b1;
          req_o.wr_addr = free_addr_q;
        end else begin
          res_d.dropped = 1'b1;
        end
        state_d = S_DONE;
      end

      S_RDREQ: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = idx_q;
        state_d       = S_RDCHK;
      end

      // Read out and clear the slot
      S_RDCHK: begin
        req_o.wr_addr = idx_q;
        if (rdata_i.used) begin
          res_d.slot_valid = 1'b1;
          res_d.owner_id   = rdata_i.owner;
          res_d.sent_total = rdata_i.sent;
          res_d.recv_total = rdata_i.recv;
          req_o.wr_en      = 1'b1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      way_q      <= '0;
      chk_q      <= 1'b0;
      chk_last_q <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      way_q      <= way_d;
      chk_q      <= chk_d;
      chk_last_q <= chk_last_d;
      found_q    <= found_d;
      free_q     <= free_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    id_q        <= id_d;
    idx_q       <= idx_d;
    chk_addr_q  <= chk_addr_d;
    tgt_addr_q  <= tgt_addr_d;
    free_addr_q <= free_addr_d;
    cur_q       <= cur_d;
    res_q       <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule
